// ===== design/alist_pkg.sv =====
`default_nettype none

package alist_pkg;

  localparam int DATA_W  = 32;
  localparam int KIND_W  = 3;
  localparam int POS_W   = 6;
  localparam int IDX_W   = 5;
  localparam int TOT_W   = 6;
  // read out never emits more entries than this
  localparam int MAX_OUT = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR  = 3'd0,
    KIND_APPEND = 3'd1,
    KIND_INSERT = 3'd2,
    KIND_DELETE = 3'd3,
    KIND_SEARCH = 3'd4,
    KIND_READ   = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_POS   = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_cmd_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

endpackage

`default_nettype wire

// ===== design/array_list_insert_delete_search_top.sv =====
`default_nettype none

// Ordered list of signed 32-bit values held in a row of LIST_DEPTH cells.
// A request is taken at a clock edge where start is high and busy is low;
// kind selects clear, append, insert, delete, search or read out.
// Every request gives at least one result; each result shows on the result
// ports for one cycle with result_valid_o high, and last_o marks the final
// result of a request. The receiver cannot stall: results are never held.
// Clear, append, insert and delete: result in the cycle after the request;
// busy stays low, so these can be issued every cycle.
// Insert and delete shift the cells from the position up at once, each from its neighbor.
// Search and read out rotate the cell ring one place a cycle for a full lap
// through cell 0's single comparator and read tap; busy is high for the lap.
// Read out emits min(count, 32) results, one per cycle, each registered
// from cell 0 during the scan; search gives one result at the end.
// Reading out an empty list gives one result straight away.
// Reset clears the entry count and the control state; cell contents are
// not reset and only entries below the count are ever reported.
module array_list_insert_delete_search_top #(
  parameter int LIST_DEPTH = 32
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 start,
  output logic                                busy,
  input  wire  [alist_pkg::KIND_W-1:0]        kind_i,
  input  wire  [alist_pkg::POS_W-1:0]         position_i,
  input  wire  signed [alist_pkg::DATA_W-1:0] item_value_i,
  output logic                                result_valid_o,
  output logic [1:0]                          status_o,
  output logic [alist_pkg::IDX_W-1:0]         result_index_o,
  output logic signed [alist_pkg::DATA_W-1:0] result_value_o,
  output logic [alist_pkg::TOT_W-1:0]         entry_total_o,
  output logic                                last_o
);
  import alist_pkg::*;

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int KW = $clog2(LIST_DEPTH);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam logic [PW-1:0] DEPTH_P = PW'(LIST_DEPTH);
  localparam logic [PW-1:0] MAXO_P  = PW'(MAX_OUT);
  localparam logic [KW-1:0] K_LAST  = KW'(LIST_DEPTH - 1);

  state_e            state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [KW-1:0]     k_q, k_d;
  logic              search_q, search_d;
  logic              found_q, found_d;
  logic [KW-1:0]     hit_idx_q, hit_idx_d;
  logic [DATA_W-1:0] key_q, key_d;

  logic              ov_q, ov_d;
  status_e           st_q, st_d;
  logic [IDX_W-1:0]  ri_q, ri_d;
  logic [DATA_W-1:0] rv_q, rv_d;
  logic [TOT_W-1:0]  tot_q, tot_d;
  logic              last_q, last_d;

  cell_cmd_e         cmd;
  logic [PW-1:0]     cell_pos;
  logic [DATA_W-1:0] cell_val [LIST_DEPTH];

  logic [PW-1:0]     cnt_ext, pos_ext, k_ext, n_out;
  logic              hit;

  assign cnt_ext = PW'(cnt_q);
  assign pos_ext = PW'(position_i);
  assign k_ext   = PW'(k_q);
  assign n_out   = (cnt_ext > MAXO_P) ? MAXO_P : cnt_ext;
  assign hit     = (k_ext < cnt_ext) && (cell_val[0] == key_q);

  assign busy = (state_q == ST_SCAN);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    k_d       = k_q;
    search_d  = search_q;
    found_d   = found_q;
    hit_idx_d = hit_idx_q;
    key_d     = key_q;
    cmd       = CELL_HOLD;
    cell_pos  = pos_ext;
    ov_d      = 1'b0;
    st_d      = st_q;
    ri_d      = ri_q;
    rv_d      = rv_q;
    tot_d     = tot_q;
    last_d    = last_q;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          ov_d   = 1'b1;
          st_d   = STAT_OK;
          ri_d   = '0;
          rv_d   = '0;
          last_d = 1'b1;
          case (kind_e'(kind_i))
            KIND_CLEAR: cnt_d = '0;
            KIND_APPEND: begin
              if (cnt_ext == DEPTH_P) begin
                st_d = STAT_FULL;
              end else begin
                cmd      = CELL_INSERT;
                cell_pos = cnt_ext;
                cnt_d    = cnt_q + 1'b1;
              end
            end
            KIND_INSERT: begin
              // position check takes priority over the full check
              if (pos_ext > cnt_ext) begin
                st_d = STAT_BAD_POS;
              end else if (cnt_ext == DEPTH_P) begin
                st_d = STAT_FULL;
              end else begin
                cmd   = CELL_INSERT;
                cnt_d = cnt_q + 1'b1;
              end
            end
            KIND_DELETE: begin
              if (pos_ext >= cnt_ext) begin
                st_d = STAT_BAD_POS;
              end else begin
                cmd   = CELL_DELETE;
                cnt_d = cnt_q - 1'b1;
              end
            end
            KIND_SEARCH: begin
              ov_d     = 1'b0;
              state_d  = ST_SCAN;
              k_d      = '0;
              search_d = 1'b1;
              found_d  = 1'b0;
              key_d    = item_value_i;
            end
            KIND_READ: begin
              if (cnt_q != '0) begin
                ov_d     = 1'b0;
                state_d  = ST_SCAN;
                k_d      = '0;
                search_d = 1'b0;
              end
            end
            default: ;
          endcase
          tot_d = TOT_W'(cnt_d);
        end
      end
      ST_SCAN: begin
        // cell 0 holds entry k during this cycle
        cmd = CELL_ROTATE;
        k_d = k_q + 1'b1;
        if (search_q) begin
          if (hit && !found_q) begin
            found_d   = 1'b1;
            hit_idx_d = k_q;
          end
          if (k_q == K_LAST) begin
            ov_d   = 1'b1;
            last_d = 1'b1;
            rv_d   = '0;
            tot_d  = TOT_W'(cnt_q);
            if (found_q) begin
              st_d = STAT_OK;
              ri_d = IDX_W'(hit_idx_q);
            end else if (hit) begin
              st_d = STAT_OK;
              ri_d = IDX_W'(k_q);
            end else begin
              st_d = STAT_NOT_FOUND;
              ri_d = '0;
            end
          end
        end else if (k_ext < n_out) begin
          ov_d   = 1'b1;
          st_d   = STAT_OK;
          ri_d   = IDX_W'(k_q);
          rv_d   = cell_val[0];
          tot_d  = TOT_W'(cnt_q);
          last_d = ((k_ext + 1'b1) == n_out);
        end
        if (k_q == K_LAST) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      k_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    search_q  <= search_d;
    found_q   <= found_d;
    hit_idx_q <= hit_idx_d;
    key_q     <= key_d;
    st_q      <= st_d;
    ri_q      <= ri_d;
    rv_q      <= rv_d;
    tot_q     <= tot_d;
    last_q    <= last_d;
  end

  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = cell_val[LIST_DEPTH-1];
    end else begin : g_mid
      assign left_w = cell_val[g-1];
    end
    if (g == LIST_DEPTH - 1) begin : g_end
      assign right_w = cell_val[0];
    end else begin : g_inner
      assign right_w = cell_val[g+1];
    end

    alist_cell #(
      .IDX (g),
      .PW  (PW)
    ) u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .pos_i       (cell_pos),
      .ins_value_i (item_value_i),
      .left_i      (left_w),
      .right_i     (right_w),
      .value_o     (cell_val[g])
    );
  end

  assign result_valid_o = ov_q;
  assign status_o       = st_q;
  assign result_index_o = ri_q;
  assign result_value_o = rv_q;
  assign entry_total_o  = tot_q;
  assign last_o         = last_q;

endmodule

`default_nettype wire

// ===== design/alist_cell.sv =====
`default_nettype none

module alist_cell #(
  parameter int IDX = 0,
  parameter int PW  = 6
) (
  input  wire                          clk_i,
  input  alist_pkg::cell_cmd_e         cmd_i,
  input  wire  [PW-1:0]                pos_i,
  input  wire  [alist_pkg::DATA_W-1:0] ins_value_i,
  input  wire  [alist_pkg::DATA_W-1:0] left_i,
  input  wire  [alist_pkg::DATA_W-1:0] right_i,
  output logic [alist_pkg::DATA_W-1:0] value_o
);
  import alist_pkg::*;

  localparam logic [PW-1:0] MY_IDX = PW'(IDX);

  logic [DATA_W-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    case (cmd_i)
      CELL_INSERT: begin
        if (MY_IDX == pos_i) begin
          value_d = ins_value_i;
        end else if (MY_IDX > pos_i) begin
          value_d = left_i;
        end
      end
      CELL_DELETE: begin
        if (MY_IDX >= pos_i) begin
          value_d = right_i;
        end
      end
      // ring shift toward cell 0; a full lap restores the order
      CELL_ROTATE: value_d = right_i;
      default:     value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

// ===== tb/alist_checker.sv =====
`timescale 1ns / 1ps

// Watches the request and result channels of the array list, keeps its own
// copy of the list and compares every result against the expected one.
module alist_checker #(
  parameter int LIST_DEPTH = 32
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire                          busy_i,
  input  wire [alist_pkg::KIND_W-1:0]  kind_i,
  input  wire [alist_pkg::POS_W-1:0]   position_i,
  input  wire [alist_pkg::DATA_W-1:0]  item_value_i,
  input  wire                          result_valid_i,
  input  wire [1:0]                    status_i,
  input  wire [alist_pkg::IDX_W-1:0]   result_index_i,
  input  wire [alist_pkg::DATA_W-1:0]  result_value_i,
  input  wire [alist_pkg::TOT_W-1:0]   entry_total_i,
  input  wire                          last_i,
  output int                           mismatch_cnt_o,
  output int                           pending_o
);
  import alist_pkg::*;

  typedef struct packed {
    status_e           status;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] value;
    logic [TOT_W-1:0]  total;
    logic              last;
  } list_result_t;

  logic [DATA_W-1:0] list_mem [0:LIST_DEPTH-1];
  int                list_len;
  list_result_t      result_q [$];
  int                mismatches;

  task automatic post_result(input status_e st, input int idx,
                             input logic [DATA_W-1:0] val, input logic lst);
    list_result_t r;
    r.status = st;
    r.index  = idx[IDX_W-1:0];
    r.value  = val;
    r.total  = list_len[TOT_W-1:0];
    r.last   = lst;
    result_q.push_back(r);
  endtask

  task automatic apply_request(input logic [KIND_W-1:0] kind,
                               input logic [POS_W-1:0] pos,
                               input logic [DATA_W-1:0] val);
    int hit;
    int n;
    hit = -1;
    n   = 0;
    case (kind)
      KIND_CLEAR: begin
        list_len = 0;
        post_result(STAT_OK, 0, '0, 1'b1);
      end
      KIND_APPEND: begin
        if (list_len >= LIST_DEPTH) begin
          post_result(STAT_FULL, 0, '0, 1'b1);
        end else begin
          list_mem[list_len] = val;
          list_len++;
          post_result(STAT_OK, 0, '0, 1'b1);
        end
      end
      KIND_INSERT: begin
        // position is checked before fullness
        if (int'(pos) > list_len) begin
          post_result(STAT_BAD_POS, 0, '0, 1'b1);
        end else if (list_len >= LIST_DEPTH) begin
          post_result(STAT_FULL, 0, '0, 1'b1);
        end else begin
          for (int i = list_len; i > int'(pos); i--) list_mem[i] = list_mem[i-1];
          list_mem[int'(pos)] = val;
          list_len++;
          post_result(STAT_OK, 0, '0, 1'b1);
        end
      end
      KIND_DELETE: begin
        if (int'(pos) >= list_len) begin
          post_result(STAT_BAD_POS, 0, '0, 1'b1);
        end else begin
          for (int i = int'(pos); i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
          post_result(STAT_OK, 0, '0, 1'b1);
        end
      end
      KIND_SEARCH: begin
        for (int i = 0; i < list_len; i++) begin
          if (hit < 0 && list_mem[i] == val) hit = i;
        end
        if (hit < 0) post_result(STAT_NOT_FOUND, 0, '0, 1'b1);
        else post_result(STAT_OK, hit, '0, 1'b1);
      end
      KIND_READ: begin
        n = (list_len > MAX_OUT) ? MAX_OUT : list_len;
        if (n == 0) begin
          post_result(STAT_OK, 0, '0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) post_result(STAT_OK, i, list_mem[i], i == n - 1);
        end
      end
      default: post_result(STAT_OK, 0, '0, 1'b1);
    endcase
  endtask

  task automatic check_result();
    list_result_t exp_r;
    if (result_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result with no request pending:", $realtime,
                 " st=%0d idx=%0d val=%0d tot=%0d last=%0b",
                 status_i, result_index_i, $signed(result_value_i),
                 entry_total_i, last_i);
    end else begin
      exp_r = result_q.pop_front();
      if (status_i !== exp_r.status || result_index_i !== exp_r.index ||
          result_value_i !== exp_r.value || entry_total_i !== exp_r.total ||
          last_i !== exp_r.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch exp st=%0d idx=%0d val=%0d tot=%0d last=%0b,",
                   $realtime, exp_r.status, exp_r.index, $signed(exp_r.value),
                   exp_r.total, exp_r.last,
                   " got st=%0d idx=%0d val=%0d tot=%0d last=%0b",
                   status_i, result_index_i, $signed(result_value_i),
                   entry_total_i, last_i);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_len = 0;
      mismatches = 0;
      result_q.delete();
      mismatch_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      // a request taken now is queued before a result on the same edge is matched
      if (start_i && !busy_i) apply_request(kind_i, position_i, item_value_i);
      if (result_valid_i) check_result();
      mismatch_cnt_o <= mismatches;
      pending_o <= result_q.size();
    end
  end

endmodule

// ===== tb/array_list_insert_delete_search_top_tb.sv =====
`timescale 1ns / 1ps

module array_list_insert_delete_search_top_tb;
  import alist_pkg::*;

  localparam int LIST_DEPTH     = 32;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PER_PH  = 35;
  // kinds outside the enum; the block must treat them as no-ops
  localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [KIND_W-1:0]        kind_i = '0;
  logic [POS_W-1:0]         position_i = '0;
  logic signed [DATA_W-1:0] item_value_i = '0;
  logic                     result_valid_o;
  logic [1:0]               status_o;
  logic [IDX_W-1:0]         result_index_o;
  logic signed [DATA_W-1:0] result_value_o;
  logic [TOT_W-1:0]         entry_total_o;
  logic                     last_o;

  int mismatch_cnt;
  int pending;
  int idle_pct;
  int len_est;
  int stall_cycles;
  int phase_idle [0:3] = '{0, 82, 0, 34};

  array_list_insert_delete_search_top #(
    .LIST_DEPTH(LIST_DEPTH)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .position_i     (position_i),
    .item_value_i   (item_value_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .result_index_o (result_index_o),
    .result_value_o (result_value_o),
    .entry_total_o  (entry_total_o),
    .last_o         (last_o)
  );

  alist_checker #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .kind_i         (kind_i),
    .position_i     (position_i),
    .item_value_i   (item_value_i),
    .result_valid_i (result_valid_o),
    .status_i       (status_o),
    .result_index_i (result_index_o),
    .result_value_i (result_value_o),
    .entry_total_i  (entry_total_o),
    .last_i         (last_o),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((start && !busy) || result_valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(3))
      0: v = $signed($urandom_range(8)) - 4;  // narrow range, so duplicates and hits
      1: begin
        case ($urandom_range(3))
          0: v = VAL_MIN;
          1: v = VAL_MAX;
          2: v = 0;
          default: v = -1;
        endcase
      end
      default: v = DATA_W'($urandom);
    endcase
    return v;
  endfunction

  // sender gap; inputs carry noise while start is low
  task automatic idle_gap();
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      kind_i <= KIND_W'($urandom);
      position_i <= POS_W'($urandom);
      item_value_i <= DATA_W'($urandom);
      @(posedge clk_i);
    end
  endtask

  task automatic send_req(input logic [KIND_W-1:0] k, input logic [POS_W-1:0] p,
                          input logic signed [DATA_W-1:0] v);
    idle_gap();
    start <= 1'b1;
    kind_i <= k;
    position_i <= p;
    item_value_i <= v;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    case (k)
      KIND_CLEAR:  len_est = 0;
      KIND_APPEND: if (len_est < LIST_DEPTH) len_est++;
      KIND_INSERT: if (int'(p) <= len_est && len_est < LIST_DEPTH) len_est++;
      KIND_DELETE: if (int'(p) < len_est) len_est--;
      default: ;
    endcase
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic random_req();
    int w;
    int r;
    logic [POS_W-1:0] p;
    w = $urandom_range(99);
    r = $urandom_range(9);
    p = POS_W'($urandom);
    if (w < 24) begin
      send_req(KIND_APPEND, p, pick_value());
    end else if (w < 44) begin
      if (r < 7) p = POS_W'($urandom_range(len_est));
      else if (r == 7) p = POS_W'(len_est + 1);
      else if (r == 8) p = POS_W'(len_est);
      send_req(KIND_INSERT, p, pick_value());
    end else if (w < 64) begin
      if (r < 7 && len_est > 0) p = POS_W'($urandom_range(len_est - 1));
      else if (r == 7) p = POS_W'(len_est);
      else if (r == 8) p = (len_est == 0) ? '0 : POS_W'(len_est - 1);
      send_req(KIND_DELETE, p, pick_value());
    end else if (w < 84) begin
      send_req(KIND_SEARCH, p, pick_value());
    end else if (w < 93) begin
      send_req(KIND_READ, p, pick_value());
    end else if (w < 97) begin
      send_req(KIND_CLEAR, p, pick_value());
    end else begin
      send_req(r[0] ? KIND_SPARE_7 : KIND_SPARE_6, p, pick_value());
    end
  endtask

  // fill to capacity, then hit the full-list cases and a maximal read out
  task automatic fill_burst();
    while (len_est < LIST_DEPTH) send_req(KIND_APPEND, POS_W'($urandom), pick_value());
    send_req(KIND_APPEND, POS_W'($urandom), pick_value());
    send_req(KIND_INSERT, POS_W'($urandom_range(LIST_DEPTH)), pick_value());
    send_req(KIND_INSERT, POS_W'(LIST_DEPTH + 1), pick_value());
    send_req(KIND_READ, POS_W'($urandom), DATA_W'($urandom));
    send_req(KIND_SEARCH, POS_W'($urandom), pick_value());
    send_req(KIND_DELETE, POS_W'(LIST_DEPTH - 1), DATA_W'($urandom));
  endtask

  initial begin
    idle_pct = 0;
    len_est = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_req(KIND_READ, 0, 0);
    send_req(KIND_SEARCH, 0, 0);
    send_req(KIND_DELETE, 0, 0);
    send_req(KIND_INSERT, 1, 7);
    send_req(KIND_INSERT, 0, VAL_MIN);
    send_req(KIND_APPEND, 0, VAL_MAX);
    send_req(KIND_APPEND, 0, -1);
    send_req(KIND_APPEND, 0, 0);
    send_req(KIND_INSERT, POS_W'(len_est), 32'sh5555_5555);
    send_req(KIND_INSERT, 2, 32'shAAAA_AAAA);
    send_req(KIND_APPEND, 0, -1);
    send_req(KIND_SEARCH, 0, -1);
    send_req(KIND_SEARCH, 0, VAL_MIN);
    send_req(KIND_SEARCH, 0, 12345);
    send_req(KIND_DELETE, 6'h3F, 0);
    send_req(KIND_DELETE, POS_W'(len_est), 0);
    send_req(KIND_DELETE, POS_W'(len_est - 1), 0);
    send_req(KIND_DELETE, 0, 0);
    send_req(KIND_READ, 0, 0);
    send_req(KIND_SPARE_6, 6'h3F, -1);
    send_req(KIND_SPARE_7, 0, 0);
    send_req(KIND_CLEAR, 0, 0);
    send_req(KIND_READ, 0, 0);
    send_req(KIND_APPEND, 6'h3F, DATA_W'($urandom));

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      idle_pct = phase_idle[ph];
      if (ph == 1 || ph == 3) fill_burst();
      repeat (RANDOM_PER_PH) random_req();
    end

    drain();
    repeat (LIST_DEPTH + 8) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
